### design/apnet_pkg.sv
// Shared types, constants and the tone lookup thresholds of the note event tracker.
`default_nettype none
package apnet_pkg;

	localparam int unsigned NCH     = 5;
	localparam int unsigned CH_W    = 3;
	localparam int unsigned PER_W   = 11;
	localparam int unsigned LEN_W   = 8;
	localparam int unsigned AMP_W   = 8;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned NOTE_W  = 7;
	localparam int unsigned VEL_W   = 8;
	localparam int unsigned DUR_W   = 16;
	localparam int unsigned NSEMI   = 12;
	localparam int unsigned NOCT    = 11;
	localparam int unsigned OCT_W   = 4;
	localparam int unsigned SEMI_W  = 4;
	localparam int unsigned XS_W    = PER_W + 1 + NOCT - 1;
	localparam int unsigned THR_W   = 16;
	localparam int unsigned QDEPTH  = 4;
	localparam int unsigned QA_W    = 2;
	localparam int unsigned QC_W    = 3;

	localparam logic [63:0] CPU_CLOCK_HZ = 64'd1789773;
	localparam logic [63:0] TONE_LHS     = CPU_CLOCK_HZ * 64'd32000000;

	// Largest period+1 that still reaches the lower edge of each semitone in octave zero.
	localparam logic [THR_W-1:0] TONE_Q [NSEMI] = '{
		THR_W'(TONE_LHS / (64'd16 * 64'd254177593)),
		THR_W'(TONE_LHS / (64'd16 * 64'd269291780)),
		THR_W'(TONE_LHS / (64'd16 * 64'd285304702)),
		THR_W'(TONE_LHS / (64'd16 * 64'd302269802)),
		THR_W'(TONE_LHS / (64'd16 * 64'd320243700)),
		THR_W'(TONE_LHS / (64'd16 * 64'd339286382)),
		THR_W'(TONE_LHS / (64'd16 * 64'd359461400)),
		THR_W'(TONE_LHS / (64'd16 * 64'd380836087)),
		THR_W'(TONE_LHS / (64'd16 * 64'd403481779)),
		THR_W'(TONE_LHS / (64'd16 * 64'd427474054)),
		THR_W'(TONE_LHS / (64'd16 * 64'd452892984)),
		THR_W'(TONE_LHS / (64'd16 * 64'd479823402))
	};

	localparam logic             REQ_SNAP    = 1'b0;
	localparam logic             REQ_FINISH  = 1'b1;
	localparam logic [CH_W-1:0]  CH_NOISE    = 3'd3;
	localparam logic [CH_W-1:0]  CH_SAMPLE   = 3'd4;
	localparam logic [CH_W-1:0]  CH_LAST     = 3'd4;
	localparam logic [7:0]       NOISE_BASE  = 8'd51;
	localparam logic [NOTE_W-1:0] SAMPLE_NOTE = 7'd28;
	localparam logic [PER_W-1:0] MIN_PERIOD  = 11'd8;
	localparam logic [DUR_W-1:0] MIN_DUR_RESET = 16'd10;

	typedef struct packed {
		logic              req;
		logic [CH_W-1:0]   channel;
		logic              cand;
		logic [NOTE_W-1:0] note;
		logic [VEL_W-1:0]  vel;
		logic [TIME_W-1:0] stamp;
	} item_t;

	typedef struct packed {
		logic [CH_W-1:0]   channel;
		logic [NOTE_W-1:0] note;
		logic [VEL_W-1:0]  vel;
		logic [TIME_W-1:0] start;
		logic [TIME_W-1:0] stop;
		logic              last;
	} result_t;

endpackage
`default_nettype wire

### design/apu_period_note_event_tracker_core.sv
// Top level of the note event tracker: stream ports, duration register and the three parts.
// A snapshot passes the front-end register and the queue; the back end registers its result beat.
// Throughput: one snapshot per cycle, paced by the back end; flushes and back-pressure stall it.
// A finish beat closes all notes, then each note open past min_duration gets its own result beat.
// Asynchronous reset closes all notes, empties the queue and sets min_duration to 10.
`default_nettype none
module apu_period_note_event_tracker_core import apnet_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [63:0] s_tdata,   // channel, period, length_count, amplitude, time_stamp
	input  wire logic        s_tuser,   // req_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [87:0]      m_tdata,   // out_channel, note_number, velocity_code, start_time, end_time
	output logic             m_tlast
);

	logic [DUR_W-1:0] min_dur_q;
	logic             q_push;
	logic             q_pop;
	logic             q_full;
	logic             q_empty;
	item_t            q_wdata;
	item_t            q_rdata;
	logic             back_busy;
	result_t          res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dur_q <= MIN_DUR_RESET;
		end else if (cfg_we) begin
			min_dur_q <= cfg_wdata;
		end
	end

	apnet_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_req     (s_tuser),
		.in_channel (s_tdata[2:0]),
		.in_period  (s_tdata[13:3]),
		.in_len     (s_tdata[21:14]),
		.in_amp     (s_tdata[29:22]),
		.in_stamp   (s_tdata[61:30]),
		.push       (q_push),
		.push_item  (q_wdata),
		.full       (q_full)
	);

	apnet_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	apnet_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.min_dur   (min_dur_q),
		.q_empty   (q_empty),
		.q_item    (q_rdata),
		.q_pop     (q_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res),
		.busy      (back_busy)
	);

	assign m_tdata = {6'b0, res.stop, res.start, res.vel, res.note, res.channel};
	assign m_tlast = res.last;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(q_push && q_full))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(q_pop && q_empty))
		else $error("queue read while empty");
	a_flush_holds: assert property (@(posedge clk) disable iff (!arst_n) back_busy |-> !q_pop)
		else $error("item taken while finish results are pending");
	a_flush_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(back_busy && (!m_tvalid || m_tready)) |=> m_tvalid)
		else $error("finish step produced no result beat");

endmodule
`default_nettype wire

### design/apnet_front.sv
// Front end: accepts input beats and turns snapshots into candidate notes and velocity codes.
`default_nettype none
module apnet_front import apnet_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              in_req,
	input  wire logic [CH_W-1:0]   in_channel,
	input  wire logic [PER_W-1:0]  in_period,
	input  wire logic [LEN_W-1:0]  in_len,
	input  wire logic [AMP_W-1:0]  in_amp,
	input  wire logic [TIME_W-1:0] in_stamp,
	output logic                   push,
	output item_t                  push_item,
	input  wire logic              full
);

	logic [PER_W:0]      x_in;
	logic [OCT_W-1:0]    oct_in;
	logic                v_s1;
	logic                req_s1;
	logic [CH_W-1:0]     ch_s1;
	logic [PER_W-1:0]    per_s1;
	logic [LEN_W-1:0]    len_s1;
	logic [AMP_W-1:0]    amp_s1;
	logic [TIME_W-1:0]   stamp_s1;
	logic [OCT_W-1:0]    oct_s1;
	logic [PER_W:0]      x_s1;
	logic [XS_W-1:0]     xs;
	logic [SEMI_W-1:0]   semi;
	logic [7:0]          tone_n;
	logic [AMP_W-1:0]    mag;
	logic [6:0]          m;
	logic                is_samp;
	logic                level_ok;
	logic                note_ok;
	logic [NOTE_W-1:0]   note;
	logic [VEL_W-1:0]    vel;

	assign x_in = {1'b0, in_period} + (PER_W+1)'(1);

	always_comb begin
		oct_in = '0;
		for (int o = 1; o < NOCT; o++) begin
			if ((XS_W'(x_in) << o) <= XS_W'(TONE_Q[0])) oct_in = OCT_W'(o);
		end
	end

	assign in_ready = !v_s1 || !full;
	assign push     = v_s1 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1   <= in_req;
			ch_s1    <= in_channel;
			per_s1   <= in_period;
			len_s1   <= in_len;
			amp_s1   <= in_amp;
			stamp_s1 <= in_stamp;
			oct_s1   <= oct_in;
		end
	end

	assign x_s1 = {1'b0, per_s1} + (PER_W+1)'(1);
	assign xs   = XS_W'(x_s1) << oct_s1;

	always_comb begin
		semi = '0;
		for (int s = 1; s < NSEMI; s++) begin
			if (xs <= XS_W'(TONE_Q[s])) semi = SEMI_W'(s);
		end
	end

	assign tone_n  = 8'(oct_s1) * 8'd12 + 8'(semi);
	assign mag     = amp_s1[AMP_W-1] ? (~amp_s1 + 8'd1) : amp_s1;
	assign is_samp = (ch_s1 == CH_SAMPLE);

	always_comb begin
		if (is_samp) begin
			m = (mag > 8'd127) ? 7'd127 : mag[6:0];
		end else begin
			m = (mag > 8'd15) ? 7'd15 : mag[6:0];
		end
	end

	assign level_ok = (len_s1 != '0) && (is_samp ? (m >= 7'd2) : (m != 7'd0));

	always_comb begin
		case (ch_s1)
			CH_NOISE: begin
				note    = NOTE_W'(NOISE_BASE - {4'b0, per_s1[3:0]});
				note_ok = 1'b1;
			end
			CH_SAMPLE: begin
				note    = SAMPLE_NOTE;
				note_ok = 1'b1;
			end
			default: begin
				note    = tone_n[NOTE_W-1:0];
				note_ok = (per_s1 >= MIN_PERIOD) && !tone_n[7];
			end
		endcase
	end

	assign vel = is_samp ? (VEL_W'({m, 1'b0}) + VEL_W'(m == 7'd127))
	                     : VEL_W'({1'b0, m} * 8'd17);

	always_comb begin
		push_item.req     = req_s1;
		push_item.channel = ch_s1;
		push_item.cand    = level_ok && note_ok;
		push_item.note    = note;
		push_item.vel     = vel;
		push_item.stamp   = stamp_s1;
	end

endmodule
`default_nettype wire

### design/apnet_fifo.sv
// Short queue of classified items between the front end and the note tracker.
`default_nettype none
module apnet_fifo import apnet_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t wdata,
	output logic       full,
	input  wire logic  pop,
	output item_t      rdata,
	output logic       empty
);

	item_t           mem_q [QDEPTH];
	logic [QA_W-1:0] wr_q;
	logic [QA_W-1:0] rd_q;
	logic [QC_W-1:0] cnt_q;

	assign full  = (cnt_q == QC_W'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

endmodule
`default_nettype wire

### design/apnet_back.sv
// Back end: per-channel open note state, note ending and the registered result beat.
`default_nettype none
module apnet_back import apnet_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [DUR_W-1:0] min_dur,
	input  wire logic             q_empty,
	input  wire item_t            q_item,
	output logic                  q_pop,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output result_t               out_res,
	output logic                  busy
);

	localparam logic MODE_IDLE  = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	logic              mode_q;
	logic [NCH-1:0]    valid_q;
	logic [NOTE_W-1:0] note_q  [NCH];
	logic [TIME_W-1:0] start_q [NCH];
	logic [VEL_W-1:0]  vel_q   [NCH];
	logic [NCH-1:0]    mask_q;
	logic [TIME_W-1:0] end_q;
	logic              out_valid_q;
	result_t           out_q;

	logic              out_free;
	logic [NCH-1:0]    long_dur;
	logic [NCH-1:0]    fmask;
	logic [CH_W-1:0]   idx;
	logic [CH_W-1:0]   rd_ch;
	logic              in_range;
	logic              is_snap;
	logic              changed;
	logic              do_snap;
	logic              emit_snap;
	logic              do_fin;
	logic              flush_step;
	logic              flush_last;

	assign out_free = !out_valid_q || out_ready;
	assign q_pop    = (mode_q == MODE_IDLE) && !q_empty && out_free;
	assign busy     = (mode_q == MODE_FLUSH);

	always_comb begin
		for (int i = 0; i < NCH; i++) begin
			long_dur[i] = (q_item.stamp - start_q[i]) > TIME_W'(min_dur);
		end
	end

	assign fmask = valid_q & long_dur;

	always_comb begin
		idx = '0;
		for (int i = NCH - 1; i >= 0; i--) begin
			if (mask_q[i]) idx = CH_W'(i);
		end
	end

	assign is_snap  = (q_item.req == REQ_SNAP);
	assign in_range = (q_item.channel <= CH_LAST);

	always_comb begin
		if (mode_q == MODE_FLUSH) begin
			rd_ch = idx;
		end else if (in_range) begin
			rd_ch = q_item.channel;
		end else begin
			rd_ch = '0;
		end
	end

	assign changed = (q_item.cand != valid_q[rd_ch])
	              || (q_item.cand && (q_item.note != note_q[rd_ch]));
	assign do_snap    = q_pop && is_snap && in_range && changed;
	assign emit_snap  = do_snap && valid_q[rd_ch] && long_dur[rd_ch];
	assign do_fin     = q_pop && (q_item.req == REQ_FINISH);
	assign flush_step = (mode_q == MODE_FLUSH) && out_free;
	assign flush_last = ((mask_q & (mask_q - 1'b1)) == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_IDLE;
			valid_q     <= '0;
			mask_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_snap) valid_q[rd_ch] <= q_item.cand;
			if (do_fin) begin
				valid_q <= '0;
				mask_q  <= fmask;
				if (fmask != '0) mode_q <= MODE_FLUSH;
			end
			if (flush_step) begin
				mask_q[idx] <= 1'b0;
				if (flush_last) mode_q <= MODE_IDLE;
			end
			if (emit_snap || flush_step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_snap && q_item.cand) begin
			note_q[rd_ch]  <= q_item.note;
			start_q[rd_ch] <= q_item.stamp;
			vel_q[rd_ch]   <= q_item.vel;
		end
		if (do_fin) end_q <= q_item.stamp;
		if (emit_snap || flush_step) begin
			out_q.channel <= rd_ch;
			out_q.note    <= note_q[rd_ch];
			out_q.vel     <= vel_q[rd_ch];
			out_q.start   <= start_q[rd_ch];
			out_q.stop    <= flush_step ? end_q : q_item.stamp;
			out_q.last    <= flush_step ? flush_last : 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule
`default_nettype wire
